// ----- rtl/hrbf_pkg.sv -----
// shared types, codes and the usage-to-ascii table for the hid report framer
package hrbf_pkg;

	// event kinds
	localparam logic [2:0] KIND_REPORT = 3'd0;
	localparam logic [2:0] KIND_TOGGLE = 3'd1;
	localparam logic [2:0] KIND_NAMING = 3'd2;
	localparam logic [2:0] KIND_PAIR   = 3'd3;
	localparam logic [2:0] KIND_DROP   = 3'd4;
	localparam logic [2:0] KIND_HOST   = 3'd5;
	localparam logic [2:0] KIND_LOST   = 3'd6;

	// send paths
	localparam logic [1:0] PATH_WIRELESS = 2'd0;
	localparam logic [1:0] PATH_WIRED    = 2'd1;
	localparam logic [1:0] PATH_NAME     = 2'd2;

	// back-end operations
	localparam logic [1:0] OP_REPORT = 2'd0;
	localparam logic [1:0] OP_NAME   = 2'd1;
	localparam logic [1:0] OP_PAIR   = 2'd2;
	localparam logic [1:0] OP_DROP   = 2'd3;

	// frame header bytes
	localparam logic [7:0] HDR_REPORT = 8'hA8;
	localparam logic [7:0] HDR_NAME   = 8'hA5;
	localparam logic [7:0] HDR_PAIR   = 8'hA6;
	localparam logic [7:0] HDR_DROP   = 8'hA7;

	// special key usages
	localparam logic [7:0] USE_ENTER = 8'h28;
	localparam logic [7:0] USE_ESC   = 8'h29;
	localparam logic [7:0] USE_BKSP  = 8'h2A;

	// one command between front and back
	typedef struct packed {
		logic [1:0]      op;
		logic [2:0]      len;
		logic [6:0][7:0] bytes;
	} cmd_t;

	localparam logic [7:0] SHIFT_DIGITS [10] = '{
		8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
	};
	localparam logic [7:0] SYM_PLAIN [13] = '{
		8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h20, 8'h3B, 8'h27, 8'h60,
		8'h2C, 8'h2E, 8'h2F
	};
	localparam logic [7:0] SYM_SHIFT [13] = '{
		8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C, 8'h20, 8'h3A, 8'h22, 8'h7E,
		8'h3C, 8'h3E, 8'h3F
	};

	// hid usage to ascii, zero when the key has no mapping
	function automatic logic [7:0] usage_to_ascii(input logic [7:0] u, input logic shift);
		logic [7:0] res;
		logic [3:0] off;
		res = '0;
		off = '0;
		if (u >= 8'h04 && u <= 8'h1D) begin
			res = (shift ? 8'h41 : 8'h61) + (u - 8'h04);
		end else if (u >= 8'h1E && u <= 8'h27) begin
			off = 4'(u - 8'h1E);
			if (shift)
				res = SHIFT_DIGITS[off];
			else if (u == 8'h27)
				res = 8'h30;
			else
				res = 8'h31 + {4'h0, off};
		end else if (u >= 8'h2C && u <= 8'h38) begin
			off = 4'(u - 8'h2C);
			res = shift ? SYM_SHIFT[off] : SYM_PLAIN[off];
		end
		return res;
	endfunction

endpackage

// ----- rtl/hrbf_cmdq.sv -----
// two-entry command queue between the front and back ends
module hrbf_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hrbf_pkg::cmd_t wr_cmd,
	output logic          space,
	output logic          q_valid,
	input  logic          pop,
	output hrbf_pkg::cmd_t rd_cmd
);
	import hrbf_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign space   = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign rd_cmd  = ent_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= wr_cmd;
	end

endmodule

// ----- rtl/hrbf_front.sv -----
// front end: takes events, keeps mode and name state, issues commands
module hrbf_front #(
	parameter int NAME_MAX = 19,
	parameter int IDX_W    = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	output logic             evt_ready,
	input  logic [2:0]       kind,
	input  logic [7:0]       modifiers,
	input  logic [7:0]       key_a,
	input  logic [7:0]       key_b,
	input  logic [7:0]       key_c,
	input  logic [7:0]       key_d,
	input  logic [7:0]       key_e,
	input  logic [7:0]       key_f,
	input  logic             cable_present,
	output logic             push,
	output hrbf_pkg::cmd_t   cmd,
	input  logic             space,
	input  logic             name_done,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [7:0]       rd_byte
);
	import hrbf_pkg::*;

	localparam int FILL_W = $clog2(NAME_MAX + 1);

	logic [1:0]          path_q, path_d;
	logic [1:0]          prev_q, prev_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic [7:0]          pair_q, pair_d;
	logic                busy_q;
	logic [NAME_MAX-1:0] vld_q;
	logic [7:0]          name_mem [NAME_MAX];
	logic [7:0]          rd_data_q;
	logic                rd_vld_q;

	logic                acc;
	logic [6:0][7:0]     rep_bytes;
	logic [2:0]          rep_len;
	logic [7:0]          ascii;
	logic [7:0]          pair_inc;
	logic [FILL_W-1:0]   fill_inc;
	logic [FILL_W-1:0]   fill_bk;
	logic                leave;
	logic                commit;
	logic [FILL_W-1:0]   fill_new;
	logic                mem_we;
	logic                vld_set;
	logic                vld_clr;
	logic                vld_clr_all;
	logic [IDX_W-1:0]    wa;

	assign evt_ready = !busy_q && space;
	assign acc       = evt_valid && evt_ready;
	assign rep_bytes = {key_f, key_e, key_d, key_c, key_b, key_a, modifiers};
	assign ascii     = usage_to_ascii(key_a, |(modifiers & 8'h22));
	assign pair_inc  = pair_q + 8'd1;
	assign fill_inc  = fill_q + FILL_W'(1);
	assign fill_bk   = (fill_q != '0) ? fill_q - FILL_W'(1) : fill_q;

	// report length: one past the last nonzero byte
	always_comb begin
		rep_len = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if (rep_bytes[i] != 8'h00)
				rep_len = 3'(i + 1);
		end
	end

	// event decode and next state
	always_comb begin
		path_d      = path_q;
		prev_d      = prev_q;
		fill_d      = fill_q;
		pair_d      = pair_q;
		push        = 1'b0;
		cmd.op      = OP_REPORT;
		cmd.len     = rep_len;
		cmd.bytes   = rep_bytes;
		mem_we      = 1'b0;
		vld_set     = 1'b0;
		vld_clr     = 1'b0;
		vld_clr_all = 1'b0;
		wa          = fill_q[IDX_W-1:0];
		leave       = 1'b0;
		commit      = 1'b0;
		fill_new    = fill_q;
		if (acc) begin
			case (kind)
				KIND_REPORT: begin
					pair_d = 8'd0;
					if (path_q == PATH_NAME) begin
						if (key_a == USE_ESC) begin
							leave = 1'b1;
						end else if (key_a == USE_ENTER) begin
							leave  = 1'b1;
							commit = 1'b1;
						end else if (key_a == USE_BKSP) begin
							fill_new = fill_bk;
							wa       = fill_bk[IDX_W-1:0];
							vld_clr  = 1'b1;
						end else if (ascii != 8'h00) begin
							mem_we   = 1'b1;
							vld_set  = 1'b1;
							fill_new = fill_inc;
							if (fill_inc >= FILL_W'(NAME_MAX)) begin
								leave  = 1'b1;
								commit = 1'b1;
							end
						end
						fill_d = fill_new;
						if (leave) begin
							if (commit && fill_new != '0) begin
								push   = 1'b1;
								cmd.op = OP_NAME;
							end
							path_d = prev_q;
							fill_d = '0;
						end
					end else if (path_q == PATH_WIRELESS) begin
						push = 1'b1;
					end
				end
				KIND_TOGGLE: begin
					prev_d = path_q;
					if (cable_present)
						path_d = (path_q == PATH_WIRED) ? PATH_WIRELESS : PATH_WIRED;
					else
						path_d = PATH_WIRELESS;
				end
				KIND_NAMING: begin
					prev_d      = path_q;
					path_d      = PATH_NAME;
					fill_d      = '0;
					vld_clr_all = 1'b1;
				end
				KIND_PAIR: begin
					pair_d = pair_inc;
					if (pair_inc == 8'd2) begin
						push   = 1'b1;
						cmd.op = OP_PAIR;
					end
				end
				KIND_DROP: begin
					push   = 1'b1;
					cmd.op = OP_DROP;
				end
				KIND_HOST: begin
					prev_d = path_q;
					path_d = PATH_WIRED;
				end
				KIND_LOST: begin
					prev_d = path_q;
					path_d = PATH_WIRELESS;
				end
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_q <= PATH_WIRELESS;
			prev_q <= PATH_WIRELESS;
			fill_q <= '0;
			pair_q <= 8'd0;
			busy_q <= 1'b0;
			vld_q  <= '0;
		end else begin
			path_q <= path_d;
			prev_q <= prev_d;
			fill_q <= fill_d;
			pair_q <= pair_d;
			if (push && cmd.op == OP_NAME)
				busy_q <= 1'b1;
			else if (name_done)
				busy_q <= 1'b0;
			if (vld_clr_all)
				vld_q <= '0;
			else if (vld_set)
				vld_q[wa] <= 1'b1;
			else if (vld_clr)
				vld_q[wa] <= 1'b0;
		end
	end

	// name memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			name_mem[wa] <= ascii;
		rd_data_q <= name_mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	assign rd_byte = rd_vld_q ? rd_data_q : 8'h00;

	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		name_done |-> busy_q)
		else $error("name commit finished with none pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(NAME_MAX))
		else $error("name fill beyond buffer");

	a_commit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.op == OP_NAME) |=> (busy_q && !evt_ready))
		else $error("events taken while a name commit is pending");

endmodule

// ----- rtl/hrbf_back.sv -----
// back end: turns queued commands into link bytes, one per cycle while tx_ready takes them
module hrbf_back #(
	parameter int NAME_MAX = 19,
	parameter int IDX_W    = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             pop,
	input  hrbf_pkg::cmd_t   rd_cmd,
	output logic [IDX_W-1:0] rd_addr,
	input  logic [7:0]       rd_byte,
	output logic             name_done,
	output logic             tx_valid,
	input  logic             tx_ready,
	output logic [7:0]       uart_byte,
	output logic             frame_end
);
	import hrbf_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RPT  = 2'd1;
	localparam logic [1:0] S_NAME = 2'd2;
	localparam logic [1:0] S_ZERO = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NAME_MAX - 1);

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] ent_q, ent_d;
	logic [2:0]       idx_q, idx_d;
	cmd_t             cur_q;
	logic             ob_valid_q;
	logic [7:0]       ob_byte_q;
	logic             ob_end_q;

	logic             load;
	logic             emit;
	logic [7:0]       byte_d;
	logic             end_d;

	assign load      = !ob_valid_q || tx_ready;
	assign rd_addr   = ent_d;
	assign tx_valid  = ob_valid_q;
	assign uart_byte = ob_byte_q;
	assign frame_end = ob_end_q;

	// byte sequencer
	always_comb begin
		state_d   = state_q;
		ent_d     = ent_q;
		idx_d     = idx_q;
		pop       = 1'b0;
		emit      = 1'b0;
		byte_d    = 8'h00;
		end_d     = 1'b0;
		name_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				ent_d = '0;
				idx_d = 3'd0;
				if (q_valid && load) begin
					pop  = 1'b1;
					emit = 1'b1;
					case (rd_cmd.op)
						OP_REPORT: begin
							byte_d = HDR_REPORT + {5'd0, rd_cmd.len};
							end_d  = (rd_cmd.len == 3'd0);
							if (rd_cmd.len != 3'd0)
								state_d = S_RPT;
						end
						OP_NAME: begin
							byte_d  = HDR_NAME;
							state_d = S_NAME;
						end
						OP_PAIR: begin
							byte_d = HDR_PAIR;
							end_d  = 1'b1;
						end
						default: begin
							byte_d = HDR_DROP;
							end_d  = 1'b1;
						end
					endcase
				end
			end
			S_RPT: begin
				if (load) begin
					emit   = 1'b1;
					byte_d = cur_q.bytes[idx_q];
					end_d  = (idx_q == cur_q.len - 3'd1);
					if (end_d)
						state_d = S_IDLE;
					else
						idx_d = idx_q + 3'd1;
				end
			end
			S_NAME: begin
				if (load) begin
					emit = 1'b1;
					if (rd_byte != 8'h00) begin
						byte_d = rd_byte;
						if (ent_q == LAST_IDX)
							state_d = S_ZERO;
						else
							ent_d = ent_q + IDX_W'(1);
					end else begin
						end_d     = 1'b1;
						state_d   = S_IDLE;
						name_done = 1'b1;
					end
				end
			end
			S_ZERO: begin
				if (load) begin
					emit      = 1'b1;
					end_d     = 1'b1;
					state_d   = S_IDLE;
					name_done = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ent_q      <= '0;
			idx_q      <= 3'd0;
			ob_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ent_q   <= ent_d;
			idx_q   <= idx_d;
			if (load)
				ob_valid_q <= emit;
		end
	end

	// current command and output byte
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= rd_cmd;
		if (emit) begin
			ob_byte_q <= byte_d;
			ob_end_q  <= end_d;
		end
	end

	a_rpt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RPT) |-> (cur_q.len != 3'd0 && idx_q < cur_q.len))
		else $error("report byte index past its length");

	a_zero_after_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ZERO) |-> (ent_q == LAST_IDX))
		else $error("name terminator before the buffer end");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !q_valid && tx_valid && tx_ready) |=> !tx_valid)
		else $error("byte shown with no command behind it");

endmodule

// ----- rtl/hid_report_to_ble_uart_framer_core.sv -----
// top level of the hid report to wireless link byte framer
// an event's first byte is stored in the command queue, then in the output byte register
// the back end gives one byte per cycle while tx_ready takes them; a name frame is its header,
// the name bytes and a zero byte, a report its header and trimmed bytes, pair and drop a header
// the front takes one event per cycle while the two-entry queue has room; it holds off new
// events from a name commit until its last byte has been handed to the output register
// reset: arst_n clears mode, name fill, pairing count, name valid bits, queue and output
module hid_report_to_ble_uart_framer_core #(
	parameter int NAME_MAX = 19
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       evt_valid,
	output logic       evt_ready,
	input  logic [2:0] kind,
	input  logic [7:0] modifiers,
	input  logic [7:0] key_a,
	input  logic [7:0] key_b,
	input  logic [7:0] key_c,
	input  logic [7:0] key_d,
	input  logic [7:0] key_e,
	input  logic [7:0] key_f,
	input  logic       cable_present,
	output logic       tx_valid,
	input  logic       tx_ready,
	output logic [7:0] uart_byte,
	output logic       frame_end
);
	import hrbf_pkg::*;

	localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

	logic             push;
	cmd_t             wr_cmd;
	logic             space;
	logic             q_valid;
	logic             pop;
	cmd_t             rd_cmd;
	logic [IDX_W-1:0] rd_addr;
	logic [7:0]       rd_byte;
	logic             name_done;

	// event decode and name state
	hrbf_front #(
		.NAME_MAX (NAME_MAX),
		.IDX_W    (IDX_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (evt_valid),
		.evt_ready     (evt_ready),
		.kind          (kind),
		.modifiers     (modifiers),
		.key_a         (key_a),
		.key_b         (key_b),
		.key_c         (key_c),
		.key_d         (key_d),
		.key_e         (key_e),
		.key_f         (key_f),
		.cable_present (cable_present),
		.push          (push),
		.cmd           (wr_cmd),
		.space         (space),
		.name_done     (name_done),
		.rd_addr       (rd_addr),
		.rd_byte       (rd_byte)
	);

	// command queue
	hrbf_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_cmd  (wr_cmd),
		.space   (space),
		.q_valid (q_valid),
		.pop     (pop),
		.rd_cmd  (rd_cmd)
	);

	// byte emission
	hrbf_back #(
		.NAME_MAX (NAME_MAX),
		.IDX_W    (IDX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (pop),
		.rd_cmd    (rd_cmd),
		.rd_addr   (rd_addr),
		.rd_byte   (rd_byte),
		.name_done (name_done),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.uart_byte (uart_byte),
		.frame_end (frame_end)
	);

endmodule
